[rtl/tlptw_pkg.sv]
// ----------------------------------------------------------------------------
// Two-level page table walker package
// Shared sizes, codes, helper functions and controller/datapath interface types.
// ----------------------------------------------------------------------------
package tlptw_pkg;

   localparam int FRAMES    = 64;
   localparam int SLOT_W    = $clog2(FRAMES);
   localparam int INDEX_W   = 10;
   localparam int ADDR_W    = SLOT_W + INDEX_W;
   localparam int VPN_W     = 20;
   localparam int FRAME_W   = 20;
   localparam int ENTRY_W   = FRAME_W + 1;
   localparam int ROOT_W    = 6;
   localparam int FREE_W    = 7;
   localparam int CSR_AW    = 3;
   localparam int CSR_DW    = 32;

   localparam logic [ROOT_W-1:0] ROOT_FRAME_RESET = '0;
   localparam logic [FREE_W-1:0] FIRST_FREE_RESET = FREE_W'(1);

   localparam logic OP_QUERY  = 1'b0;
   localparam logic OP_UPDATE = 1'b1;

   localparam logic STATUS_OK       = 1'b0;
   localparam logic STATUS_NO_FRAME = 1'b1;

   localparam logic CSR_IDX_ROOT_FRAME = 1'b0;
   localparam logic CSR_IDX_FIRST_FREE = 1'b1;

   typedef enum logic [1:0] {
      OUT_NONE     = 2'b00,
      OUT_NO_FRAME = 2'b01,
      OUT_LEAF     = 2'b10
   } out_sel_type;

   typedef struct packed {
      logic        clear_step;
      logic        accept;
      logic        read_leaf;
      logic        link_root;
      logic        alloc_root;
      logic        write_leaf;
      logic        out_load;
      out_sel_type out_sel;
   } ctrl_cmd_type;

   typedef struct packed {
      logic clear_done;
      logic op_update;
      logic unmap;
      logic root_valid;
      logic exhausted;
      logic out_free;
   } dp_status_type;

   typedef struct packed {
      logic [ROOT_W-1:0] root_frame;
      logic [FREE_W-1:0] first_free;
      logic              load_next_free;
   } cfg_type;

   // Frame numbers are taken modulo FRAMES, a power of two.
   function automatic logic [SLOT_W-1:0] frame_slot(input logic [FRAME_W-1:0] frame);
      return frame[SLOT_W-1:0];
   endfunction

   function automatic logic [ENTRY_W-1:0] make_entry(input logic [FRAME_W-1:0] frame);
      return {frame, 1'b1};
   endfunction

endpackage

[rtl/two_level_page_table_walker.sv]
// ----------------------------------------------------------------------------
// Two-level page table walker
// Walks and maintains a two-level page table held in an on-chip frame store.
// ----------------------------------------------------------------------------
// After reset the frame store is cleared one entry per cycle; requests are
// held off during that pass while register writes are taken as usual. All
// table accesses go to the frame store one at a time, at most one access per
// cycle, so a request occupies the walker for the root entry read, then either
// the leaf read of a query or the leaf write of an update (preceded in the
// same pass by the root link when a table frame is allocated). The response
// is registered; a new request may be accepted while the previous response
// still waits to be taken.
module two_level_page_table_walker (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  req_valid,
   output logic                                  req_stall,
   input  logic                                  req_operation,
   input  logic [tlptw_pkg::VPN_W-1:0]           req_virtual_page,
   input  logic [tlptw_pkg::FRAME_W-1:0]         req_target_frame,
   input  logic                                  req_unmap,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_mapped,
   output logic [tlptw_pkg::FRAME_W-1:0]         rsp_found_frame,
   output logic                                  rsp_status,
   input  logic                                  csr_psel,
   input  logic                                  csr_penable,
   input  logic                                  csr_pwrite,
   input  logic [tlptw_pkg::CSR_AW-1:0]          csr_paddr,
   input  logic [tlptw_pkg::CSR_DW-1:0]          csr_pwdata,
   output logic [tlptw_pkg::CSR_DW-1:0]          csr_prdata,
   output logic                                  csr_pready
);

   tlptw_pkg::ctrl_cmd_type  cmd;
   tlptw_pkg::dp_status_type sts;
   tlptw_pkg::cfg_type       cfg;

   logic                           ctrl_idle;
   logic                           csr_write;
   logic                           csr_index;
   logic [tlptw_pkg::ROOT_W-1:0]   root_frame_ff;
   logic [tlptw_pkg::ROOT_W-1:0]   root_frame_in;
   logic [tlptw_pkg::FREE_W-1:0]   first_free_ff;
   logic [tlptw_pkg::FREE_W-1:0]   first_free_in;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign csr_index  = csr_paddr[2];

   always_comb begin
      root_frame_in = root_frame_ff;
      first_free_in = first_free_ff;
      if (csr_write && (csr_index == tlptw_pkg::CSR_IDX_ROOT_FRAME)) begin
         root_frame_in = csr_pwdata[tlptw_pkg::ROOT_W-1:0];
      end
      if (csr_write && (csr_index == tlptw_pkg::CSR_IDX_FIRST_FREE)) begin
         first_free_in = csr_pwdata[tlptw_pkg::FREE_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         root_frame_ff <= tlptw_pkg::ROOT_FRAME_RESET;
         first_free_ff <= tlptw_pkg::FIRST_FREE_RESET;
      end else begin
         root_frame_ff <= root_frame_in;
         first_free_ff <= first_free_in;
      end
   end

   always_comb begin
      if (csr_index == tlptw_pkg::CSR_IDX_FIRST_FREE) begin
         csr_prdata = tlptw_pkg::CSR_DW'(first_free_ff);
      end else begin
         csr_prdata = tlptw_pkg::CSR_DW'(root_frame_ff);
      end
   end

   assign cfg.root_frame     = root_frame_ff;
   assign cfg.first_free     = first_free_in;
   assign cfg.load_next_free = csr_write && (csr_index == tlptw_pkg::CSR_IDX_FIRST_FREE);

   assign req_stall = !ctrl_idle;

   tlptw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .sts       (sts),
      .cmd       (cmd),
      .idle      (ctrl_idle)
   );

   tlptw_dp u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .sts              (sts),
      .cfg              (cfg),
      .req_operation    (req_operation),
      .req_virtual_page (req_virtual_page),
      .req_target_frame (req_target_frame),
      .req_unmap        (req_unmap),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_mapped       (rsp_mapped),
      .rsp_found_frame  (rsp_found_frame),
      .rsp_status       (rsp_status)
   );

`ifndef SYNTHESIS
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("walker accepted a request without becoming busy");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_valid || !rsp_stall))
      else $error("response register loaded while a response is held");

   a_status_not_mapped: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> !rsp_mapped)
      else $error("failed update reported as a mapping");
`endif

endmodule

[rtl/tlptw_ctrl.sv]
// ----------------------------------------------------------------------------
// Page table walker controller
// Sequences the clear pass, the root read, the leaf access and the response.
// ----------------------------------------------------------------------------
module tlptw_ctrl (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     req_valid,
   input  tlptw_pkg::dp_status_type sts,
   output tlptw_pkg::ctrl_cmd_type  cmd,
   output logic                     idle
);

   typedef enum logic [4:0] {
      ST_CLEAR = 5'b00001,
      ST_IDLE  = 5'b00010,
      ST_ROOT  = 5'b00100,
      ST_LEAF  = 5'b01000,
      ST_WLEAF = 5'b10000
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
            if (sts.clear_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_valid) begin
               cmd.accept = 1'b1;
               state_in   = ST_ROOT;
            end
         end
         ST_ROOT: begin
            priority if (sts.root_valid && !sts.op_update) begin
               cmd.read_leaf = 1'b1;
               state_in      = ST_LEAF;
            end else if (sts.root_valid) begin
               cmd.link_root = 1'b1;
               state_in      = ST_WLEAF;
            end else if (!sts.op_update || sts.unmap) begin
               if (sts.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = tlptw_pkg::OUT_NONE;
                  state_in     = ST_IDLE;
               end
            end else if (sts.exhausted) begin
               if (sts.out_free) begin
                  cmd.out_load = 1'b1;
                  cmd.out_sel  = tlptw_pkg::OUT_NO_FRAME;
                  state_in     = ST_IDLE;
               end
            end else begin
               cmd.alloc_root = 1'b1;
               state_in       = ST_WLEAF;
            end
         end
         ST_LEAF: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               cmd.out_sel  = tlptw_pkg::OUT_LEAF;
               state_in     = ST_IDLE;
            end
         end
         ST_WLEAF: begin
            if (sts.out_free) begin
               cmd.write_leaf = 1'b1;
               cmd.out_load   = 1'b1;
               cmd.out_sel    = tlptw_pkg::OUT_NONE;
               state_in       = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   assign idle = (state_ff == ST_IDLE);

endmodule

[rtl/tlptw_dp.sv]
// ----------------------------------------------------------------------------
// Page table walker datapath
// Frame store, request registers, table allocator and response register.
// ----------------------------------------------------------------------------
module tlptw_dp (
   input  logic                                  clock,
   input  logic                                  reset,
   input  tlptw_pkg::ctrl_cmd_type               cmd,
   output tlptw_pkg::dp_status_type              sts,
   input  tlptw_pkg::cfg_type                    cfg,
   input  logic                                  req_operation,
   input  logic [tlptw_pkg::VPN_W-1:0]           req_virtual_page,
   input  logic [tlptw_pkg::FRAME_W-1:0]         req_target_frame,
   input  logic                                  req_unmap,
   output logic                                  rsp_valid,
   input  logic                                  rsp_stall,
   output logic                                  rsp_mapped,
   output logic [tlptw_pkg::FRAME_W-1:0]         rsp_found_frame,
   output logic                                  rsp_status
);

   logic [tlptw_pkg::ENTRY_W-1:0] mem [2**tlptw_pkg::ADDR_W];

   logic [tlptw_pkg::ADDR_W-1:0]  clr_addr_ff;
   logic [tlptw_pkg::ADDR_W-1:0]  clr_addr_in;
   logic [tlptw_pkg::FREE_W-1:0]  next_free_ff;
   logic [tlptw_pkg::FREE_W-1:0]  next_free_in;
   logic                          op_ff;
   logic [tlptw_pkg::VPN_W-1:0]   vpage_ff;
   logic [tlptw_pkg::FRAME_W-1:0] target_ff;
   logic                          unmap_ff;
   logic [tlptw_pkg::ENTRY_W-1:0] rd_data_ff;
   logic [tlptw_pkg::FRAME_W-1:0] tbl_frame_ff;
   logic                          rsp_valid_ff;
   logic                          rsp_valid_in;
   logic                          rsp_mapped_ff;
   logic [tlptw_pkg::FRAME_W-1:0] rsp_frame_ff;
   logic                          rsp_status_ff;

   logic [tlptw_pkg::ADDR_W-1:0]  rd_addr;
   logic                          rd_en;
   logic [tlptw_pkg::ADDR_W-1:0]  wr_addr;
   logic [tlptw_pkg::ENTRY_W-1:0] wr_data;
   logic                          wr_en;
   logic [tlptw_pkg::ADDR_W-1:0]  root_addr;
   logic [tlptw_pkg::INDEX_W-1:0] low_index;

   assign low_index = vpage_ff[tlptw_pkg::INDEX_W-1:0];
   assign root_addr = {tlptw_pkg::frame_slot(tlptw_pkg::FRAME_W'(cfg.root_frame)),
                       vpage_ff[tlptw_pkg::VPN_W-1:tlptw_pkg::INDEX_W]};

   always_comb begin
      rd_en = cmd.accept || cmd.read_leaf;
      if (cmd.accept) begin
         rd_addr = {tlptw_pkg::frame_slot(tlptw_pkg::FRAME_W'(cfg.root_frame)),
                    req_virtual_page[tlptw_pkg::VPN_W-1:tlptw_pkg::INDEX_W]};
      end else begin
         rd_addr = {tlptw_pkg::frame_slot(rd_data_ff[tlptw_pkg::ENTRY_W-1:1]), low_index};
      end
   end

   always_comb begin
      wr_en = cmd.clear_step || cmd.alloc_root || cmd.write_leaf;
      priority if (cmd.clear_step) begin
         wr_addr = clr_addr_ff;
         wr_data = '0;
      end else if (cmd.alloc_root) begin
         wr_addr = root_addr;
         wr_data = tlptw_pkg::make_entry(tlptw_pkg::FRAME_W'(next_free_ff));
      end else begin
         wr_addr = {tlptw_pkg::frame_slot(tbl_frame_ff), low_index};
         wr_data = unmap_ff ? '0 : tlptw_pkg::make_entry(target_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff     <= req_operation;
         vpage_ff  <= req_virtual_page;
         target_ff <= req_target_frame;
         unmap_ff  <= req_unmap;
      end
      if (cmd.link_root) begin
         tbl_frame_ff <= rd_data_ff[tlptw_pkg::ENTRY_W-1:1];
      end else if (cmd.alloc_root) begin
         tbl_frame_ff <= tlptw_pkg::FRAME_W'(next_free_ff);
      end
   end

   always_comb begin
      clr_addr_in  = cmd.clear_step ? clr_addr_ff + tlptw_pkg::ADDR_W'(1) : clr_addr_ff;
      next_free_in = next_free_ff;
      if (cfg.load_next_free) begin
         next_free_in = cfg.first_free;
      end else if (cmd.alloc_root) begin
         next_free_in = next_free_ff + tlptw_pkg::FREE_W'(1);
      end
      rsp_valid_in = cmd.out_load || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_addr_ff  <= '0;
         next_free_ff <= tlptw_pkg::FIRST_FREE_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         clr_addr_ff  <= clr_addr_in;
         next_free_ff <= next_free_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.out_load) begin
         unique case (cmd.out_sel)
            tlptw_pkg::OUT_LEAF: begin
               rsp_mapped_ff <= rd_data_ff[0];
               rsp_frame_ff  <= rd_data_ff[0] ? rd_data_ff[tlptw_pkg::ENTRY_W-1:1] : '0;
               rsp_status_ff <= tlptw_pkg::STATUS_OK;
            end
            tlptw_pkg::OUT_NO_FRAME: begin
               rsp_mapped_ff <= 1'b0;
               rsp_frame_ff  <= '0;
               rsp_status_ff <= tlptw_pkg::STATUS_NO_FRAME;
            end
            default: begin
               rsp_mapped_ff <= 1'b0;
               rsp_frame_ff  <= '0;
               rsp_status_ff <= tlptw_pkg::STATUS_OK;
            end
         endcase
      end
   end

   assign sts.clear_done = (clr_addr_ff == '1);
   assign sts.op_update  = (op_ff == tlptw_pkg::OP_UPDATE);
   assign sts.unmap      = unmap_ff;
   assign sts.root_valid = rd_data_ff[0];
   assign sts.exhausted  = (32'(next_free_ff) >= tlptw_pkg::FRAMES);
   assign sts.out_free   = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_mapped      = rsp_mapped_ff;
   assign rsp_found_frame = rsp_frame_ff;
   assign rsp_status      = rsp_status_ff;

endmodule
